// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge out of reset.
`define BPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bpc assertion failed");

// Check that a condition is never true on a clock edge out of reset.
`define BPC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bpc forbidden condition seen");

`endif

// ===== src/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier files.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int NUM_LANES = 3;
  localparam int CFG_W     = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // lane order inside the result vector
  localparam int LANE_UP    = 0;
  localparam int LANE_DOWN  = 1;
  localparam int LANE_ENTER = 2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_LONG  = 2'd0;
  localparam logic [1:0] REG_DELAY = 2'd1;
  localparam logic [1:0] REG_RATE  = 2'd2;

  localparam logic [CFG_W-1:0] LONG_RESET  = 16'd800;
  localparam logic [CFG_W-1:0] DELAY_RESET = 16'd400;
  localparam logic [CFG_W-1:0] RATE_RESET  = 16'd150;

  typedef struct packed {
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] delay_ticks;
    logic [CFG_W-1:0] rate_ticks;
  } bpc_cfg_t;

  typedef struct packed {
    logic press;
    logic short_rel;
    logic long_hold;
    logic repeat_ev;
  } bpc_evt_t;

  typedef bpc_evt_t [NUM_LANES-1:0] bpc_result_t;

endpackage

`default_nettype wire

// ===== src/bpc_in_if.sv =====
// ----------------------------------------------------------------------------
// bpc_in_if
// Input channel: one tick carrying the raw active-low button levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_in_if;
  logic valid;
  logic ready;
  logic up_level;
  logic down_level;
  logic enter_level;

  modport source (output valid, output up_level, output down_level,
                  output enter_level, input ready);
  modport sink (input valid, input up_level, input down_level,
                input enter_level, output ready);
endinterface

`default_nettype wire

// ===== src/bpc_out_if.sv =====
// ----------------------------------------------------------------------------
// bpc_out_if
// Output channel: per-button press, short, long and repeat events of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_out_if;
  logic valid;
  logic ready;
  logic up_press;
  logic up_short;
  logic up_long;
  logic up_repeat;
  logic down_press;
  logic down_short;
  logic down_long;
  logic down_repeat;
  logic enter_press;
  logic enter_short;
  logic enter_long;
  logic enter_repeat;

  modport source (output valid, input ready,
                  output up_press, output up_short, output up_long, output up_repeat,
                  output down_press, output down_short, output down_long,
                  output down_repeat, output enter_press, output enter_short,
                  output enter_long, output enter_repeat);
  modport sink (input valid, output ready,
                input up_press, input up_short, input up_long, input up_repeat,
                input down_press, input down_short, input down_long,
                input down_repeat, input enter_press, input enter_short,
                input enter_long, input enter_repeat);
endinterface

`default_nettype wire

// ===== src/button_press_classifier_top.sv =====
// A tick's events reach out_o via the output register, or the skid stage on a stall.
// One tick per cycle unless the skid is full; the three lane timers update together.
// A two-entry output buffer lets one more input transfer in once the output stalls.
// Reset (rst_ni low, asynchronous) clears all lane state and the output buffer and
// loads the thresholds with 800, 400 and 150 ticks.
// ----------------------------------------------------------------------------
// button_press_classifier_top
// Three-button press classifier with APB-style threshold registers.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_top
  import bpc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bpc_in_if.sink                 in_i,
  bpc_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  bpc_cfg_t   cfg_q;
  logic       cfg_we;
  logic [1:0] reg_idx;
  logic       in_ready, in_fire;
  logic [NUM_LANES-1:0] levels;
  bpc_evt_t   lane_evt [NUM_LANES];

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks  <= LONG_RESET;
      cfg_q.delay_ticks <= DELAY_RESET;
      cfg_q.rate_ticks  <= RATE_RESET;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_LONG:  cfg_q.long_ticks  <= pwdata[CFG_W-1:0];
        REG_DELAY: cfg_q.delay_ticks <= pwdata[CFG_W-1:0];
        REG_RATE:  cfg_q.rate_ticks  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LONG:  prdata = DATA_W'(cfg_q.long_ticks);
      REG_DELAY: prdata = DATA_W'(cfg_q.delay_ticks);
      REG_RATE:  prdata = DATA_W'(cfg_q.rate_ticks);
      default:   prdata = '0;
    endcase
  end

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid & in_ready;

  assign levels[LANE_UP]    = in_i.up_level;
  assign levels[LANE_DOWN]  = in_i.down_level;
  assign levels[LANE_ENTER] = in_i.enter_level;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    bpc_lane #(
      .TIMER_BITS(TIMER_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (in_fire),
      .level_i(levels[k]),
      .cfg_i  (cfg_q),
      .evt_o  (lane_evt[k])
    );
  end

  bpc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .evt_i     (lane_evt),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== src/bpc_lane.sv =====
// ----------------------------------------------------------------------------
// bpc_lane
// Per-button classifier: hold timer, long-press flag and auto-repeat schedule.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpc_lane
  import bpc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     level_i,
  input  wire bpc_cfg_t cfg_i,
  output bpc_evt_t      evt_o
);

  localparam int XW = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
  localparam logic [XW-1:0] TMAX_X = XW'((65'd1 << TIMER_BITS) - 65'd1);

  logic                  held_q, held_d;
  logic                  ld_q, ld_d;
  logic [TIMER_BITS-1:0] hold_q, hold_d;
  logic [TIMER_BITS-1:0] nra_q, nra_d;
  logic [TIMER_BITS-1:0] lim_long, lim_delay;
  logic [XW-1:0]         long_x, delay_x, sum_x;
  logic                  pressed;

  assign pressed = ~level_i;
  assign long_x  = XW'(cfg_i.long_ticks);
  assign delay_x = XW'(cfg_i.delay_ticks);

  // thresholds above the counter range act as the counter maximum
  assign lim_long  = (long_x > TMAX_X) ? '1 : long_x[TIMER_BITS-1:0];
  assign lim_delay = (delay_x > TMAX_X) ? '1 : delay_x[TIMER_BITS-1:0];

  always_comb begin
    held_d = held_q;
    ld_d   = ld_q;
    hold_d = hold_q;
    nra_d  = nra_q;
    evt_o  = '0;
    sum_x  = '0;
    if (pressed && !held_q) begin
      held_d      = 1'b1;
      hold_d      = '0;
      ld_d        = 1'b0;
      nra_d       = lim_delay;
      evt_o.press = 1'b1;
    end else if (!pressed && held_q) begin
      held_d          = 1'b0;
      evt_o.short_rel = ~ld_q;
      ld_d            = 1'b0;
    end else if (pressed && held_q) begin
      if (hold_q != '1) begin
        hold_d = hold_q + TIMER_BITS'(1);
      end
      if (!ld_q && (hold_d >= lim_long)) begin
        ld_d            = 1'b1;
        evt_o.long_hold = 1'b1;
      end
    end
    sum_x = XW'(hold_d) + XW'(cfg_i.rate_ticks);
    if (held_d && !ld_d && (hold_d >= lim_delay) && (hold_d >= nra_d)) begin
      nra_d           = (sum_x > TMAX_X) ? '1 : sum_x[TIMER_BITS-1:0];
      evt_o.repeat_ev = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      ld_q   <= 1'b0;
      hold_q <= '0;
      nra_q  <= '0;
    end else if (en_i) begin
      held_q <= held_d;
      ld_q   <= ld_d;
      hold_q <= hold_d;
      nra_q  <= nra_d;
    end
  end

  `BPC_ASSERT_NEVER(a_press_alone, en_i && evt_o.press && (evt_o.long_hold || evt_o.short_rel))
  `BPC_ASSERT(a_long_sticks, en_i && evt_o.long_hold |=> ld_q && held_q)
  `BPC_ASSERT(a_long_needs_hold, ld_q |-> held_q)

endmodule

`default_nettype wire

// ===== src/bpc_merge.sv =====
// ----------------------------------------------------------------------------
// bpc_merge
// Collects the lane events into one result and buffers it in an output
// register with a skid stage behind it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpc_merge
  import bpc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bpc_evt_t evt_i [NUM_LANES],
  bpc_out_if.source     out_o
);

  bpc_result_t res_new;
  bpc_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_fire, out_free;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      res_new[k] = evt_i[k];
    end
  end

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        // drain the skid stage first, keeps order
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (in_fire) begin
      skid_q <= res_new;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.up_press     = out_q[LANE_UP].press;
  assign out_o.up_short     = out_q[LANE_UP].short_rel;
  assign out_o.up_long      = out_q[LANE_UP].long_hold;
  assign out_o.up_repeat    = out_q[LANE_UP].repeat_ev;
  assign out_o.down_press   = out_q[LANE_DOWN].press;
  assign out_o.down_short   = out_q[LANE_DOWN].short_rel;
  assign out_o.down_long    = out_q[LANE_DOWN].long_hold;
  assign out_o.down_repeat  = out_q[LANE_DOWN].repeat_ev;
  assign out_o.enter_press  = out_q[LANE_ENTER].press;
  assign out_o.enter_short  = out_q[LANE_ENTER].short_rel;
  assign out_o.enter_long   = out_q[LANE_ENTER].long_hold;
  assign out_o.enter_repeat = out_q[LANE_ENTER].repeat_ev;

  `BPC_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q)
  `BPC_ASSERT(a_stall_fills_skid, in_fire && out_valid_q && !out_o.ready |=> skid_valid_q)

endmodule

`default_nettype wire
